// ===== rtl/skr_pkg.sv =====
// Package: shared constants, types and helpers for the k-point reducer.
package skr_pkg;

	localparam int MaxOps       = 48;
	localparam int MaxClasses   = 4096;
	localparam int MatDepth     = MaxOps * 9;
	localparam int MatAw        = $clog2(MatDepth);
	localparam int ClsAw        = $clog2(MaxClasses);
	localparam int CntW         = ClsAw + 1;
	localparam int OpW          = 6;

	localparam logic [1:0] CmdLoad     = 2'd0;
	localparam logic [1:0] CmdClassify = 2'd1;
	localparam logic [1:0] CmdClear    = 2'd2;

	localparam logic [1:0] RegOpCount = 2'd0;
	localparam logic [1:0] RegMatchTol = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MRD,     // matrix element read issued
		ST_MUL,     // multiply element by coordinate
		ST_ACC,     // accumulate product
		ST_AXIS,    // finish one axis (saturate)
		ST_SCAN,    // issue class read
		ST_CMP,     // compare registered class
		ST_UPD,     // write weight
		ST_NEW,     // store new class
		ST_OUT      // result waits
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       cap_point;     // latch input point
		logic       clr_acc;       // clear axis accumulator
		logic       mul_en;        // register product
		logic       acc_en;        // add product into accumulator
		logic       axis_done;     // saturate and store rotated axis
		logic [1:0] axis;          // axis under rotation
		logic [1:0] col;           // matrix column / point coordinate
		logic       hit_upd;       // latch match result
		logic       new_cls;       // write new class
		logic       res_full;      // emit full-table result
		logic       res_zero;      // emit all-zero result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;
	} dp_sts_t;

	function automatic logic [31:0] sat_axis(input logic signed [65:0] v);
		if (v > 66'sd2147483647)       return 32'h7fffffff;
		else if (v < -66'sd2147483648) return 32'h80000000;
		else                           return v[31:0];
	endfunction

endpackage

// ===== rtl/skr_ram.sv =====
// Generic RAM with one write port and one registered read port.
module skr_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/skr_datapath.sv =====
// Datapath: rotation multiply-accumulate, class compare and result register.
module skr_datapath (
	input  logic                        clk,
	input  skr_pkg::dp_cmd_t            cmd_i,
	output skr_pkg::dp_sts_t            sts_o,
	input  logic [31:0]                 point_x,
	input  logic [31:0]                 point_y,
	input  logic [31:0]                 point_z,
	input  logic [31:0]                 mat_rdata,
	input  logic [95:0]                 cls_rdata,
	input  logic [15:0]                 wgt_rdata,
	input  logic [24:0]                 tol,
	input  logic [skr_pkg::ClsAw-1:0]   scan_idx,
	output logic [95:0]                 rot_o,
	output logic [15:0]                 wgt_new,
	output logic [11:0]                 class_index,
	output logic                        is_new,
	output logic [15:0]                 class_weight,
	output logic                        table_full,
	output logic [31:0]                 rep_x,
	output logic [31:0]                 rep_y,
	output logic [31:0]                 rep_z
);
	import skr_pkg::*;

	logic [31:0]        pt_q [3];
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic [31:0]        rot_q [3];
	logic [32:0]        ma, mb, d;
	logic               ok [3];
	logic               sa, sb;
	logic [31:0]        a, b;

	always_ff @(posedge clk) begin
		if (cmd_i.cap_point) begin
			pt_q[0] <= point_x;
			pt_q[1] <= point_y;
			pt_q[2] <= point_z;
		end
		if (cmd_i.mul_en) begin
			prod_q <= $signed(mat_rdata) * $signed(pt_q[cmd_i.col]);
		end
		if (cmd_i.clr_acc) begin
			acc_q <= '0;
		end else if (cmd_i.acc_en) begin
			acc_q <= acc_q + 66'(prod_q);
		end
		if (cmd_i.axis_done) begin
			// floor shift of the exact three-term sum
			rot_q[cmd_i.axis] <= sat_axis(acc_q >>> 24);
		end
	end

	assign rot_o = {rot_q[2], rot_q[1], rot_q[0]};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a = rot_q[k];
			b = cls_rdata[32*k +: 32];
			ma = a[31] ? 33'(-$signed({a[31], a})) : {1'b0, a};
			mb = b[31] ? 33'(-$signed({b[31], b})) : {1'b0, b};
			d  = (ma >= mb) ? ma - mb : mb - ma;
			sa = (a != '0);
			sb = (b != '0);
			ok[k] = (a[31] == b[31]) && (sa == sb) && (d < {8'd0, tol});
		end
	end
	assign sts_o.match = ok[0] && ok[1] && ok[2];
	assign wgt_new = (wgt_rdata == 16'hffff) ? wgt_rdata : wgt_rdata + 16'd1;

	always_ff @(posedge clk) begin
		if (cmd_i.hit_upd) begin
			class_index  <= 12'(scan_idx);
			is_new       <= 1'b0;
			class_weight <= wgt_new;
			table_full   <= 1'b0;
			{rep_z, rep_y, rep_x} <= cls_rdata;
		end else if (cmd_i.new_cls) begin
			class_index  <= 12'(scan_idx);
			is_new       <= 1'b1;
			class_weight <= 16'd1;
			table_full   <= 1'b0;
			{rep_z, rep_y, rep_x} <= rot_o;
		end else if (cmd_i.res_full || cmd_i.res_zero) begin
			class_index  <= '0;
			is_new       <= 1'b0;
			class_weight <= '0;
			table_full   <= cmd_i.res_full;
			{rep_z, rep_y, rep_x} <= '0;
		end
	end
endmodule

// ===== rtl/skr_ctrl.sv =====
// Controller: sequences operations, axes and the class scan.
module skr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_go,
	input  logic [1:0]                 cmd,
	input  logic [skr_pkg::OpW-1:0]    op_lim,
	input  skr_pkg::dp_sts_t           sts_i,
	input  logic                       out_take,
	output skr_pkg::dp_cmd_t           cmd_o,
	output skr_pkg::state_t            state_o,
	output logic [skr_pkg::MatAw-1:0]  mat_raddr,
	output logic [skr_pkg::ClsAw-1:0]  cls_idx,
	output logic                       cls_we,
	output logic                       wgt_we
);
	import skr_pkg::*;

	state_t         st_q, st_d;
	logic [5:0]     op_q, op_d;
	logic [1:0]     ax_q, ax_d, col_q, col_d;
	logic [CntW-1:0] cnt_q, cnt_d, j_q, j_d;

	assign state_o = st_q;
	assign cls_idx = j_q[ClsAw-1:0];
	assign mat_raddr = MatAw'(op_q * 9 + ax_q * 3 + col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; op_q <= '0; ax_q <= '0; col_q <= '0;
			cnt_q <= '0; j_q <= '0;
		end else begin
			st_q <= st_d; op_q <= op_d; ax_q <= ax_d; col_q <= col_d;
			cnt_q <= cnt_d; j_q <= j_d;
		end
	end

	always_comb begin
		st_d = st_q; op_d = op_q; ax_d = ax_q; col_d = col_q;
		cnt_d = cnt_q; j_d = j_q;
		cmd_o = '0;
		cmd_o.axis = ax_q;
		cmd_o.col = col_q;
		cls_we = 1'b0; wgt_we = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (in_go) begin
					if (cmd == CmdClassify) begin
						cmd_o.cap_point = 1'b1;
						cmd_o.clr_acc = 1'b1;
						op_d = '0; ax_d = '0; col_d = '0;
						st_d = ST_MRD;
					end else begin
						if (cmd == CmdClear) cnt_d = '0;
						cmd_o.res_zero = 1'b1;
						st_d = ST_OUT;
					end
				end
			end
			ST_MRD: st_d = ST_MUL;
			ST_MUL: begin
				cmd_o.mul_en = 1'b1;
				st_d = ST_ACC;
			end
			ST_ACC: begin
				cmd_o.acc_en = 1'b1;
				if (col_q == 2'd2) begin
					col_d = '0;
					st_d = ST_AXIS;
				end else begin
					col_d = col_q + 2'd1;
					st_d = ST_MRD;
				end
			end
			ST_AXIS: begin
				cmd_o.axis_done = 1'b1;
				cmd_o.clr_acc = 1'b1;
				if (ax_q == 2'd2) begin
					ax_d = '0;
					j_d = '0;
					st_d = ST_SCAN;
				end else begin
					ax_d = ax_q + 2'd1;
					st_d = ST_MRD;
				end
			end
			ST_SCAN: begin
				if (j_q < cnt_q) begin
					st_d = ST_CMP;
				end else if (op_q + 6'd1 < op_lim) begin
					op_d = op_q + 6'd1;
					st_d = ST_MRD;
				end else if (cnt_q >= CntW'(MaxClasses)) begin
					cmd_o.res_full = 1'b1;
					st_d = ST_OUT;
				end else begin
					j_d = cnt_q;
					st_d = ST_NEW;
				end
			end
			ST_CMP: begin
				if (sts_i.match) begin
					cmd_o.hit_upd = 1'b1;
					wgt_we = 1'b1;
					st_d = ST_OUT;
				end else begin
					j_d = j_q + 1'b1;
					st_d = ST_SCAN;
				end
			end
			ST_NEW: begin
				cmd_o.new_cls = 1'b1;
				cls_we = 1'b1;
				wgt_we = 1'b1;
				cnt_d = cnt_q + 1'b1;
				st_d = ST_OUT;
			end
			ST_OUT: if (out_take) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/symmetry_kpoint_reducer_core.sv =====
// Top level: k-point reducer with APB registers, controller, datapath and RAMs.
//
//  channel | signals                         | beat taken when
//  in      | in_valid/in_ready + 7 fields    | in_valid & in_ready
//  out     | out_valid/out_ready + 7 fields  | out_valid & out_ready
//  cfg     | APB psel/penable/pwrite/paddr   | psel & penable & pwrite
//
// Load, clear and unused commands put their zero result out in the cycle
// after the beat. A classify beat takes each operation in turn: for each of
// 3 axes, 3 columns are read, multiplied and accumulated in turn, then the
// axis saturates; the stored classes are then scanned (registered RAM read
// then compare per class). A hit ends the search; after the last operation
// a new class is written, or a full-table result is given. The single shared
// multiplier and the one class-store read port serve all of this. One item
// is in flight at a time; a waiting result holds the block until taken.
// Reset clears the control state and the class count; RAM contents are left as they are.
module symmetry_kpoint_reducer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [5:0]  op_index,
	input  logic [3:0]  element_index,
	input  logic [31:0] element_value,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] class_index,
	output logic        is_new,
	output logic [15:0] class_weight,
	output logic        table_full,
	output logic [31:0] rep_x,
	output logic [31:0] rep_y,
	output logic [31:0] rep_z,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import skr_pkg::*;

	logic [5:0]  op_count_q;
	logic [24:0] tol_q;
	logic [5:0]  op_lim;
	dp_cmd_t     dcmd;
	dp_sts_t     dsts;
	state_t      st;
	logic [MatAw-1:0] mat_raddr;
	logic [ClsAw-1:0] cls_idx;
	logic        cls_we, wgt_we, mat_we;
	logic [31:0] mat_rdata;
	logic [95:0] cls_rdata, rot;
	logic [15:0] wgt_rdata, wgt_new;
	logic        in_go;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q <= 6'd1;
			tol_q      <= 25'd17;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				RegOpCount[0]:  op_count_q <= pwdata[5:0];
				RegMatchTol[0]: tol_q      <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegOpCount[0]:  prdata = {26'd0, op_count_q};
			RegMatchTol[0]: prdata = {7'd0, tol_q};
			default: prdata = '0;
		endcase
	end

	// out-of-range counts clamp to 1..MaxOps
	assign op_lim = (op_count_q == '0) ? 6'd1 :
		(op_count_q > 6'(MaxOps)) ? 6'(MaxOps) : op_count_q;

	assign in_ready  = (st == ST_IDLE);
	assign in_go     = in_valid && in_ready;
	assign out_valid = (st == ST_OUT);

	assign mat_we = in_go && (cmd == CmdLoad) && (op_index < 6'(MaxOps))
		&& (element_index < 4'd9);

	skr_ram #(.Width(32), .Depth(MatDepth)) u_mat (
		.clk(clk), .we(mat_we),
		.waddr(MatAw'(op_index * 9 + element_index)), .wdata(element_value),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	skr_ram #(.Width(96), .Depth(MaxClasses)) u_cls (
		.clk(clk), .we(cls_we), .waddr(cls_idx), .wdata(rot),
		.raddr(cls_idx), .rdata(cls_rdata)
	);

	skr_ram #(.Width(16), .Depth(MaxClasses)) u_wgt (
		.clk(clk), .we(wgt_we), .waddr(cls_idx),
		.wdata(cls_we ? 16'd1 : wgt_new),
		.raddr(cls_idx), .rdata(wgt_rdata)
	);

	skr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .cmd(cmd), .op_lim(op_lim),
		.sts_i(dsts), .out_take(out_valid && out_ready), .cmd_o(dcmd),
		.state_o(st), .mat_raddr(mat_raddr), .cls_idx(cls_idx),
		.cls_we(cls_we), .wgt_we(wgt_we)
	);

	skr_datapath u_dp (
		.clk(clk), .cmd_i(dcmd), .sts_o(dsts),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.mat_rdata(mat_rdata), .cls_rdata(cls_rdata), .wgt_rdata(wgt_rdata),
		.tol(tol_q), .scan_idx(cls_idx), .rot_o(rot), .wgt_new(wgt_new),
		.class_index(class_index), .is_new(is_new),
		.class_weight(class_weight), .table_full(table_full),
		.rep_x(rep_x), .rep_y(rep_y), .rep_z(rep_z)
	);

	// a held result blocks new beats
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result waits");
	// class store is written only when a new class is emitted
	a_new_cls: assert property (@(posedge clk) disable iff (!arst_n)
		cls_we |=> (out_valid && is_new)) else $error("new class without result");
	// a full-table result carries no class
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!is_new && class_weight == 16'd0))
		else $error("full result carries class data");

endmodule

// ===== tb/symmetry_kpoint_reducer_core_tb.sv =====
// Testbench for the k-point reducer: scoreboard class, random stimulus, APB setup.
module symmetry_kpoint_reducer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import skr_pkg::*;

	localparam logic [31:0] One      = 32'h0100_0000;   // 1.0 in Q8.24
	localparam logic [1:0]  CmdSpare = 2'd3;            // unused code, block gives a zero result
	localparam int          CycleLimit = 3_000_000;

	typedef struct {
		logic [1:0]  cmd;
		logic [5:0]  op;
		logic [3:0]  el;
		logic [31:0] ev, px, py, pz;
	} kp_beat_t;

	typedef struct {
		logic [11:0] idx;
		logic        nw;
		logic [15:0] wt;
		logic        full;
		logic [31:0] rx, ry, rz;
	} kp_result_t;

	// Scoreboard: own copy of matrices, class table and registers.
	class kpoint_tally;
		logic signed [31:0] mat [MatDepth];
		logic signed [31:0] crd [MaxClasses][3];
		logic [15:0]        wgt [MaxClasses];
		int                 n_cls;
		logic [5:0]         op_cnt;
		logic [24:0]        tol;
		kp_result_t         due [$];
		int                 errs;

		function new();
			n_cls  = 0;
			op_cnt = 6'd1;
			tol    = 25'd17;
			errs   = 0;
		endfunction

		function void set_reg(logic [1:0] r, logic [31:0] v);
			if (r == RegOpCount)
				op_cnt = v[5:0];
			else if (r == RegMatchTol)
				tol = v[24:0];
		endfunction

		function int pending();
			return due.size();
		endfunction

		// full-precision sum of three products, floor shift, saturate
		function logic signed [31:0] rot_axis(int base, logic signed [31:0] p [3]);
			logic signed [65:0] acc;
			acc = '0;
			for (int i = 0; i < 3; i++)
				acc = acc + 66'(mat[base + i]) * 66'(p[i]);
			acc = acc >>> 24;
			if (acc > 66'sd2147483647)
				return 32'sh7fffffff;
			if (acc < -66'sd2147483648)
				return 32'sh80000000;
			return acc[31:0];
		endfunction

		function int sgn(logic signed [31:0] v);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		function bit axis_hit(logic signed [31:0] a, logic signed [31:0] b);
			logic signed [33:0] ma, mb, d;
			ma = (a < 0) ? -34'(a) : 34'(a);
			mb = (b < 0) ? -34'(b) : 34'(b);
			d  = ma - mb;
			if (d < 0)
				d = -d;
			return (sgn(a) == sgn(b)) && (d < 34'(tol));
		endfunction

		function void note_item(kp_beat_t b);
			kp_result_t         r;
			logic signed [31:0] p [3];
			logic signed [31:0] rot [3];
			int                 n;
			r = '{default: '0};
			rot = '{default: '0};
			if (b.cmd == CmdLoad) begin
				if (b.op < MaxOps && b.el < 9)
					mat[b.op * 9 + b.el] = b.ev;
			end else if (b.cmd == CmdClear) begin
				n_cls = 0;
			end else if (b.cmd == CmdClassify) begin
				p = '{b.px, b.py, b.pz};
				n = (op_cnt == 0) ? 1 : ((op_cnt > MaxOps) ? MaxOps : op_cnt);
				for (int o = 0; o < n; o++) begin
					for (int k = 0; k < 3; k++)
						rot[k] = rot_axis(o * 9 + k * 3, p);
					for (int j = 0; j < n_cls; j++) begin
						if (axis_hit(rot[0], crd[j][0]) && axis_hit(rot[1], crd[j][1]) &&
								axis_hit(rot[2], crd[j][2])) begin
							if (wgt[j] != 16'hffff)
								wgt[j]++;
							r.idx = j[11:0];
							r.wt  = wgt[j];
							r.rx  = crd[j][0];
							r.ry  = crd[j][1];
							r.rz  = crd[j][2];
							due.insert(due.size(), r);
							return;
						end
					end
				end
				if (n_cls >= MaxClasses) begin
					r.full = 1'b1;
				end else begin
					crd[n_cls] = rot;
					wgt[n_cls] = 16'd1;
					r.idx = n_cls[11:0];
					r.nw  = 1'b1;
					r.wt  = 16'd1;
					r.rx  = rot[0];
					r.ry  = rot[1];
					r.rz  = rot[2];
					n_cls++;
				end
			end
			due.insert(due.size(), r);
		endfunction

		function void check_result(kp_result_t got);
			kp_result_t e;
			if (due.size() == 0) begin
				$error("result beat with nothing expected");
				errs++;
				return;
			end
			e = due.pop_front();
			if (got.idx !== e.idx) begin
				$error("class_index exp %0d got %0d", e.idx, got.idx); errs++;
			end
			if (got.nw !== e.nw) begin
				$error("is_new exp %0d got %0d", e.nw, got.nw); errs++;
			end
			if (got.wt !== e.wt) begin
				$error("class_weight exp %0d got %0d", e.wt, got.wt); errs++;
			end
			if (got.full !== e.full) begin
				$error("table_full exp %0d got %0d", e.full, got.full); errs++;
			end
			if (got.rx !== e.rx) begin
				$error("rep_x exp %h got %h", e.rx, got.rx); errs++;
			end
			if (got.ry !== e.ry) begin
				$error("rep_y exp %h got %h", e.ry, got.ry); errs++;
			end
			if (got.rz !== e.rz) begin
				$error("rep_z exp %h got %h", e.rz, got.rz); errs++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  cmd;
	logic [5:0]  op_index;
	logic [3:0]  element_index;
	logic [31:0] element_value, point_x, point_y, point_z;
	logic [11:0] class_index;
	logic        is_new, table_full;
	logic [15:0] class_weight;
	logic [31:0] rep_x, rep_y, rep_z;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	kpoint_tally tally = new();
	bit          quiet = 0;      // set for the closing stretch: no idling anywhere
	int          stall_left = 0;
	int          cycles = 0;

	symmetry_kpoint_reducer_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("symmetry_kpoint_reducer_core_tb failed");
			$finish;
		end
	end

	// Result side: random back-pressure bursts, beat checked on accept
	always @(posedge clk) begin
		if (out_valid && out_ready)
			tally.check_result(kp_result_t'{class_index, is_new, class_weight,
				table_full, rep_x, rep_y, rep_z});
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One input beat; valid stays high into the next call unless a gap is drawn
	task automatic send(kp_beat_t b);
		in_valid      <= 1'b1;
		cmd           <= b.cmd;
		op_index      <= b.op;
		element_index <= b.el;
		element_value <= b.ev;
		point_x       <= b.px;
		point_y       <= b.py;
		point_z       <= b.pz;
		do
			@(posedge clk);
		while (!in_ready);
		tally.note_item(b);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic apb_write(logic [1:0] r, logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(r) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tally.set_reg(r, v);
	endtask

	// Every beat gives one result, so an empty queue means the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tally.pending() != 0)
			@(posedge clk);
	endtask

	function automatic kp_beat_t mk(logic [1:0] c, logic [5:0] o, logic [3:0] e,
			logic [31:0] v, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		kp_beat_t b;
		b = '{c, o, e, v, x, y, z};
		return b;
	endfunction

	// Coordinates: mostly a coarse grid so rotations land on earlier classes
	function automatic logic [31:0] coord();
		case ($urandom_range(0, 9))
			6:       return 32'h0;
			7:       return $urandom();
			8:       return 32'h7fff_ffff;
			9:       return 32'h8000_0000;
			default: return 32'(int'($urandom_range(0, 8)) - 4) <<< 22;
		endcase
	endfunction

	// Load a whole signed-permutation matrix, now and then one raw element
	task automatic load_op(int o);
		int perm [3];
		int t, s;
		logic [31:0] v;
		perm = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			s = $urandom_range(0, i);
			t = perm[i]; perm[i] = perm[s]; perm[s] = t;
		end
		for (int e = 0; e < 9; e++) begin
			v = (perm[e / 3] == e % 3) ? ($urandom_range(0, 1) ? One : -One) : 32'h0;
			if ($urandom_range(0, 15) == 0)
				v = $urandom();
			send(mk(CmdLoad, 6'(o), 4'(e), v, $urandom(), $urandom(), $urandom()));
		end
	endtask

	task automatic random_items(int count);
		kp_beat_t b;
		int       r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			b = mk(CmdClassify, 6'($urandom()), 4'($urandom()), $urandom(), coord(),
				coord(), coord());
			if (r < 20) begin
				// overwrite one element of a loaded op, sometimes out of range
				b.cmd = CmdLoad;
				b.op  = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, MaxOps - 1));
				b.el  = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 8));
				case ($urandom_range(0, 3))
					0: b.ev = One;
					1: b.ev = -One;
					2: b.ev = 32'h0;
					default: b.ev = $urandom();
				endcase
			end else if (r < 25) begin
				b.cmd = CmdClear;
			end else if (r < 28) begin
				b.cmd = CmdSpare;
			end
			send(b);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CmdLoad;
		op_index      = '0;
		element_index = '0;
		element_value = '0;
		point_x       = '0;
		point_y       = '0;
		point_z       = '0;
		out_ready     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: op 0 identity, op 1 carries the element extremes
		for (int e = 0; e < 9; e++)
			send(mk(CmdLoad, 6'd0, 4'(e), (e % 4 == 0) ? One : 32'h0, 0, 0, 0));
		for (int e = 0; e < 9; e++)
			send(mk(CmdLoad, 6'd1, 4'(e), (e == 0) ? 32'h7fff_ffff :
				((e == 4) ? 32'h8000_0000 : ((e == 8) ? One : 32'h0)), 0, 0, 0));
		send(mk(CmdLoad, 6'd63, 4'd15, 32'hdead_beef, 0, 0, 0));  // out of range
		send(mk(CmdSpare, 6'd0, 4'd0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		send(mk(CmdClassify, 0, 0, 0, 32'h0, 32'h0, 32'h0));        // zero point
		send(mk(CmdClassify, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000));
		send(mk(CmdClassify, 0, 0, 0, 32'h7fff_fff0, 32'h8000_0008, 32'h0100_0000));
		send(mk(CmdClear, 0, 0, 0, 0, 0, 0));
		send(mk(CmdClassify, 0, 0, 0, 32'h0, 32'h0, 32'h0));
		drain();

		// Two ops, extremes in op 1 saturate the rotation
		apb_write(RegOpCount, 32'd2);
		load_op(2);
		load_op(3);
		random_items(30);
		drain();

		// Zero count acts as one; a wide tolerance of 1.0 matches nearby points of the same sign
		apb_write(RegOpCount, 32'd0);
		apb_write(RegMatchTol, 32'd16777216);
		random_items(25);
		drain();

		// Zero tolerance: every classify opens a class
		apb_write(RegOpCount, 32'd4);
		apb_write(RegMatchTol, 32'd0);
		random_items(25);
		drain();

		// Fill the rest of the matrix store, then run with all ops
		for (int o = 4; o < MaxOps; o++)
			load_op(o);
		drain();
		apb_write(RegOpCount, 32'd48);
		apb_write(RegMatchTol, $urandom_range(1, 1 << 23));
		send(mk(CmdClear, 0, 0, 0, 0, 0, 0));
		random_items(20);
		drain();

		// Count above the maximum, default tolerance, no idling from here on
		apb_write(RegOpCount, 32'd63);
		apb_write(RegMatchTol, 32'd17);
		quiet = 1;
		@(posedge clk);
		stall_left = 0;
		send(mk(CmdClear, 0, 0, 0, 0, 0, 0));
		random_items(20);
		drain();

		repeat (20) @(posedge clk);
		if (tally.errs == 0 && tally.pending() == 0)
			$display("symmetry_kpoint_reducer_core_tb passed");
		else
			$display("symmetry_kpoint_reducer_core_tb failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/skr_pkg.sv
rtl/skr_ram.sv
rtl/skr_datapath.sv
rtl/skr_ctrl.sv
rtl/symmetry_kpoint_reducer_core.sv
tb/symmetry_kpoint_reducer_core_tb.sv
